### design/fts_pkg.sv
// Package for the fork trigger state machine: command, state, status and
// override codes, and field widths. No dependencies.
`timescale 1ns / 1ps

package fts_pkg;

    localparam int CNT_W             = 4;
    localparam int MAX_NEIGHBORS_DEF = 8;

    typedef enum logic [3:0] {
        CMD_STOP        = 4'd0,
        CMD_START       = 4'd1,
        CMD_PAUSE       = 4'd2,
        CMD_RELEASE     = 4'd3,
        CMD_SUSPEND     = 4'd4,
        CMD_RESUME      = 4'd5,
        CMD_RESET       = 4'd6,
        CMD_PREPARE     = 4'd7,
        CMD_XRUN        = 4'd8,
        CMD_PRE_START   = 4'd9,
        CMD_PRE_RELEASE = 4'd10
    } cmd_t;

    typedef enum logic [2:0] {
        STATE_INIT       = 3'd0,
        STATE_READY      = 3'd1,
        STATE_SUSPEND    = 3'd2,
        STATE_PREPARE    = 3'd3,
        STATE_PRE_ACTIVE = 3'd4,
        STATE_ACTIVE     = 3'd5,
        STATE_PAUSED     = 3'd6
    } state_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_STOP     = 2'd1,
        STATUS_INVALID  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OVR_NONE        = 2'd0,
        OVR_PAUSE       = 2'd1,
        OVR_RELEASE     = 2'd2,
        OVR_PRE_RELEASE = 2'd3
    } ovr_t;

endpackage

### design/fork_trigger_state_machine.sv
// Fork trigger state machine: top level with input register, transition
// logic and result register. Depends on fts_pkg.
//
// Usage:
//   Slave stream s_axis carries one trigger command per transfer together
//   with the counts of neighboring paths that are active and paused. The
//   master stream m_axis returns exactly one result per command: status,
//   override command and the state after the command.
//   A command passes the input register, then the result register, to m_axis.
//   Throughput is one command per cycle while the receiver does not stall:
//   the transition table over the 3-bit state register is evaluated in
//   one pass between the input register and the result register, and the
//   state updates as the item moves into the result register.
//   Reset puts the state in init and empties both registers.
//   When the receiver stalls, the result is held; one more command waits
//   in the input register, after which s_axis_tready drops until the
//   result is taken.
//   Counts above MAX_NEIGHBORS are saturated to MAX_NEIGHBORS.
`timescale 1ns / 1ps

module fork_trigger_state_machine #(
    parameter int MAX_NEIGHBORS = fts_pkg::MAX_NEIGHBORS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] cmd, [7:4] active_count, [11:8] paused_count, [15:12] zero
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [3:2] override_cmd, [6:4] new_state, [7] zero
    output logic [7:0]  m_axis_tdata
);

    localparam int CMP_W = $clog2(MAX_NEIGHBORS + 1) + fts_pkg::CNT_W;

    logic                       in_valid_reg;
    logic [3:0]                 cmd_reg;
    logic [fts_pkg::CNT_W-1:0]  act_reg;
    logic [fts_pkg::CNT_W-1:0]  pau_reg;

    fts_pkg::state_t            state_reg;
    fts_pkg::state_t            state_next;

    logic                       out_valid_reg;
    fts_pkg::status_t           status_reg;
    fts_pkg::ovr_t              ovr_reg;
    fts_pkg::state_t            new_state_reg;

    fts_pkg::status_t           status_c;
    fts_pkg::ovr_t              ovr_c;

    logic [CMP_W-1:0]           act_sat;
    logic [CMP_W-1:0]           pau_sat;
    logic                       act_any;
    logic                       pau_any;
    logic                       pau_many;
    logic                       advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            cmd_reg <= s_axis_tdata[3:0];
            act_reg <= s_axis_tdata[7:4];
            pau_reg <= s_axis_tdata[11:8];
        end
    end

    // Saturate counts to the neighbor limit
    always_comb
    begin
        act_sat = CMP_W'(act_reg);
        pau_sat = CMP_W'(pau_reg);
        if (act_sat > CMP_W'(MAX_NEIGHBORS))
        begin
            act_sat = CMP_W'(MAX_NEIGHBORS);
        end
        if (pau_sat > CMP_W'(MAX_NEIGHBORS))
        begin
            pau_sat = CMP_W'(MAX_NEIGHBORS);
        end
    end

    assign act_any  = (act_sat != '0);
    assign pau_any  = (pau_sat != '0);
    assign pau_many = (pau_sat > CMP_W'(1));

    // Output decode: status and override for the current command
    always_comb
    begin
        status_c = fts_pkg::STATUS_INVALID;
        ovr_c    = fts_pkg::OVR_NONE;
        case (cmd_reg)
            fts_pkg::CMD_STOP:
            begin
                if (state_reg == fts_pkg::STATE_ACTIVE)
                begin
                    if (act_any)
                    begin
                        status_c = fts_pkg::STATUS_STOP;
                    end
                    else
                    begin
                        status_c = fts_pkg::STATUS_OK;
                        if (pau_any)
                        begin
                            ovr_c = fts_pkg::OVR_PAUSE;
                        end
                    end
                end
            end
            fts_pkg::CMD_START:
            begin
                if (state_reg == fts_pkg::STATE_PRE_ACTIVE)
                begin
                    status_c = fts_pkg::STATUS_OK;
                    if (pau_any)
                    begin
                        ovr_c = fts_pkg::OVR_RELEASE;
                    end
                end
                else if (state_reg == fts_pkg::STATE_ACTIVE)
                begin
                    status_c = fts_pkg::STATUS_STOP;
                end
            end
            fts_pkg::CMD_PAUSE:
            begin
                if (state_reg == fts_pkg::STATE_ACTIVE)
                begin
                    status_c = (act_any || pau_many) ? fts_pkg::STATUS_STOP
                                                     : fts_pkg::STATUS_OK;
                end
            end
            fts_pkg::CMD_RELEASE:
            begin
                if (state_reg == fts_pkg::STATE_ACTIVE)
                begin
                    status_c = fts_pkg::STATUS_STOP;
                end
                else if (state_reg == fts_pkg::STATE_PRE_ACTIVE)
                begin
                    status_c = fts_pkg::STATUS_OK;
                end
            end
            fts_pkg::CMD_RESET:
            begin
                if (state_reg == fts_pkg::STATE_INIT ||
                    state_reg == fts_pkg::STATE_READY ||
                    state_reg == fts_pkg::STATE_SUSPEND ||
                    state_reg == fts_pkg::STATE_PREPARE ||
                    state_reg == fts_pkg::STATE_ACTIVE ||
                    state_reg == fts_pkg::STATE_PAUSED)
                begin
                    status_c = fts_pkg::STATUS_OK;
                end
            end
            fts_pkg::CMD_PREPARE:
            begin
                if (state_reg == fts_pkg::STATE_READY)
                begin
                    status_c = fts_pkg::STATUS_OK;
                end
                else if (state_reg == fts_pkg::STATE_PREPARE ||
                         state_reg == fts_pkg::STATE_ACTIVE)
                begin
                    status_c = fts_pkg::STATUS_STOP;
                end
            end
            fts_pkg::CMD_PRE_START:
            begin
                if (state_reg == fts_pkg::STATE_PREPARE)
                begin
                    status_c = fts_pkg::STATUS_OK;
                end
                else if (state_reg == fts_pkg::STATE_ACTIVE)
                begin
                    status_c = fts_pkg::STATUS_STOP;
                end
                else if (state_reg == fts_pkg::STATE_PAUSED)
                begin
                    status_c = fts_pkg::STATUS_OK;
                    ovr_c    = fts_pkg::OVR_PRE_RELEASE;
                end
            end
            fts_pkg::CMD_PRE_RELEASE:
            begin
                if (state_reg == fts_pkg::STATE_ACTIVE)
                begin
                    status_c = fts_pkg::STATUS_STOP;
                end
                else if (state_reg == fts_pkg::STATE_PAUSED)
                begin
                    status_c = fts_pkg::STATUS_OK;
                end
            end
            default:
            begin
                status_c = fts_pkg::STATUS_INVALID;
            end
        endcase
    end

    // Next state: move only on an ok status, else hold
    always_comb
    begin
        state_next = state_reg;
        if (status_c == fts_pkg::STATUS_OK)
        begin
            case (cmd_reg)
                fts_pkg::CMD_STOP:
                begin
                    state_next = pau_any ? fts_pkg::STATE_PAUSED
                                         : fts_pkg::STATE_PREPARE;
                end
                fts_pkg::CMD_START:       state_next = fts_pkg::STATE_ACTIVE;
                fts_pkg::CMD_PAUSE:       state_next = fts_pkg::STATE_PAUSED;
                fts_pkg::CMD_RELEASE:     state_next = fts_pkg::STATE_ACTIVE;
                fts_pkg::CMD_RESET:       state_next = fts_pkg::STATE_READY;
                fts_pkg::CMD_PREPARE:     state_next = fts_pkg::STATE_PREPARE;
                fts_pkg::CMD_PRE_START:   state_next = fts_pkg::STATE_PRE_ACTIVE;
                fts_pkg::CMD_PRE_RELEASE: state_next = fts_pkg::STATE_PRE_ACTIVE;
                default:                  state_next = state_reg;
            endcase
        end
    end

    // State and result registers advance together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fts_pkg::STATE_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg    <= status_c;
            ovr_reg       <= ovr_c;
            new_state_reg <= state_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, new_state_reg, ovr_reg, status_reg};

endmodule

### dv/fork_trigger_state_machine_test.sv
// Self-checking bench for fork_trigger_state_machine: a table of directed commands, then
// random commands, mostly state-aware, each checked against a local transition predictor.
// Depends on fts_pkg and the design top level.
`timescale 1ns / 1ps

module fork_trigger_state_machine_test;

    import fts_pkg::*;

    localparam int MAX_NEIGHBORS  = MAX_NEIGHBORS_DEF;
    localparam int DRILL_ROWS     = 26;
    localparam int ITEMS_PER_LEG  = 240;
    localparam int HOLD_CYCLES    = 48;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    localparam logic [3:0] CMD_UNKNOWN_TOP = 4'd15;

    typedef enum int {
        LEG_STEADY,
        LEG_SENDER_IDLE,
        LEG_RECEIVER_STALL,
        LEG_BOTH_IDLE
    } leg_t;

    // [7] zero, [6:4] new_state, [3:2] override_cmd, [1:0] status
    typedef struct packed {
        logic    pad;
        state_t  new_state;
        ovr_t    ovr;
        status_t status;
    } result_t;

    typedef struct packed {
        logic [3:0] cmd;
        logic [3:0] act;
        logic [3:0] pau;
        bit         typed;
        result_t    res;
    } drill_row_t;

    localparam result_t NO_RESULT    = '0;
    localparam result_t INIT_INVALID = '{1'b0, STATE_INIT, OVR_NONE, STATUS_INVALID};
    localparam result_t READY_OK     = '{1'b0, STATE_READY, OVR_NONE, STATUS_OK};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [3:0] cmd, [7:4] active_count, [11:8] paused_count, [15:12] zero
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [1:0] status, [3:2] override_cmd, [6:4] new_state, [7] zero
    logic [7:0]  m_axis_tdata;

    state_t     tracked_state = STATE_INIT;
    result_t    pending_results [$];
    drill_row_t drill [DRILL_ROWS];
    int         mismatches = 0;
    int         results_seen = 0;
    int         sender_idle_pct = 0;
    int         receiver_stall_pct = 0;
    int         stall_cycles;
    logic       hold_req = 1'b0;
    logic       hold_seen = 1'b0;
    result_t    got_res;
    result_t    want_res;

    fork_trigger_state_machine #(
        .MAX_NEIGHBORS(MAX_NEIGHBORS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic result_t fork_transition(input state_t s, input logic [3:0] cmd,
                                                input logic [3:0] act_raw,
                                                input logic [3:0] pau_raw);
        int      act;
        int      pau;
        result_t r;
        act = (act_raw > MAX_NEIGHBORS) ? MAX_NEIGHBORS : act_raw;
        pau = (pau_raw > MAX_NEIGHBORS) ? MAX_NEIGHBORS : pau_raw;
        r.pad       = 1'b0;
        r.status    = STATUS_INVALID;
        r.ovr       = OVR_NONE;
        r.new_state = s;
        case (cmd)
            CMD_STOP:
                if (s == STATE_ACTIVE)
                begin
                    if (act > 0)
                        r.status = STATUS_STOP;
                    else
                    begin
                        r.status = STATUS_OK;
                        if (pau > 0)
                        begin
                            r.ovr       = OVR_PAUSE;
                            r.new_state = STATE_PAUSED;
                        end
                        else
                            r.new_state = STATE_PREPARE;
                    end
                end
            CMD_START:
                if (s == STATE_PRE_ACTIVE)
                begin
                    r.status    = STATUS_OK;
                    r.new_state = STATE_ACTIVE;
                    if (pau > 0)
                        r.ovr = OVR_RELEASE;
                end
                else if (s == STATE_ACTIVE)
                    r.status = STATUS_STOP;
            CMD_PAUSE:
                if (s == STATE_ACTIVE)
                begin
                    if (act > 0 || pau > 1)
                        r.status = STATUS_STOP;
                    else
                    begin
                        r.status    = STATUS_OK;
                        r.new_state = STATE_PAUSED;
                    end
                end
            CMD_RELEASE:
                if (s == STATE_ACTIVE)
                    r.status = STATUS_STOP;
                else if (s == STATE_PRE_ACTIVE)
                begin
                    r.status    = STATUS_OK;
                    r.new_state = STATE_ACTIVE;
                end
            CMD_RESET:
                // every defined state except pre_active returns to ready
                if (s <= STATE_PAUSED && s != STATE_PRE_ACTIVE)
                begin
                    r.status    = STATUS_OK;
                    r.new_state = STATE_READY;
                end
            CMD_PREPARE:
                if (s == STATE_READY)
                begin
                    r.status    = STATUS_OK;
                    r.new_state = STATE_PREPARE;
                end
                else if (s == STATE_PREPARE || s == STATE_ACTIVE)
                    r.status = STATUS_STOP;
            CMD_PRE_START:
                if (s == STATE_PREPARE)
                begin
                    r.status    = STATUS_OK;
                    r.new_state = STATE_PRE_ACTIVE;
                end
                else if (s == STATE_ACTIVE)
                    r.status = STATUS_STOP;
                else if (s == STATE_PAUSED)
                begin
                    r.status    = STATUS_OK;
                    r.new_state = STATE_PRE_ACTIVE;
                    r.ovr       = OVR_PRE_RELEASE;
                end
            CMD_PRE_RELEASE:
                if (s == STATE_ACTIVE)
                    r.status = STATUS_STOP;
                else if (s == STATE_PAUSED)
                begin
                    r.status    = STATUS_OK;
                    r.new_state = STATE_PRE_ACTIVE;
                end
            default:
                ;
        endcase
        return r;
    endfunction

    // Pick a command that moves the machine on from the given state.
    function automatic logic [3:0] forward_cmd(input state_t s);
        logic [3:0] c;
        int         pick;
        pick = $urandom_range(9);
        case (s)
            STATE_READY:      c = (pick < 8) ? CMD_PREPARE : CMD_RESET;
            STATE_PREPARE:    c = (pick < 8) ? CMD_PRE_START : CMD_RESET;
            STATE_PRE_ACTIVE: c = (pick < 5) ? CMD_START : CMD_RELEASE;
            STATE_ACTIVE:     c = (pick < 4) ? CMD_STOP : (pick < 9) ? CMD_PAUSE : CMD_RESET;
            STATE_PAUSED:     c = (pick < 4) ? CMD_PRE_START :
                                  (pick < 8) ? CMD_PRE_RELEASE : CMD_RESET;
            default:          c = CMD_RESET;
        endcase
        return c;
    endfunction

    // Mostly zero or small counts so the zero/nonzero branches split; now and then the full
    // 4-bit range to exercise saturation.
    function automatic logic [3:0] neighbor_count();
        logic [3:0] n;
        if ($urandom_range(3) == 0)
            n = 4'($urandom_range(15));
        else if ($urandom_range(1) == 0)
            n = 4'd0;
        else
            n = 4'($urandom_range(2));
        return n;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 what, results_seen, got, want);
        mismatches++;
    endtask

    task automatic send_command(input logic [3:0] cmd, input logic [3:0] act,
                                input logic [3:0] pau, input bit typed,
                                input result_t typed_res);
        result_t res;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= {4'd0, pau, act, cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        res = fork_transition(tracked_state, cmd, act, pau);
        tracked_state = res.new_state;
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // Receiver: random stalls, plus one long hold-off each time the stimulus toggles hold_req.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(posedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_res = m_axis_tdata;
            if (pending_results.size() == 0)
                flag_mismatch("unexpected transfer", m_axis_tdata, 0);
            else
            begin
                want_res = pending_results.pop_front();
                if (got_res.status !== want_res.status)
                    flag_mismatch("status", got_res.status, want_res.status);
                if (got_res.ovr !== want_res.ovr)
                    flag_mismatch("override_cmd", got_res.ovr, want_res.ovr);
                if (got_res.new_state !== want_res.new_state)
                    flag_mismatch("new_state", got_res.new_state, want_res.new_state);
                if (got_res.pad !== 1'b0)
                    flag_mismatch("padding bit", got_res.pad, 0);
            end
            results_seen++;
        end
    end

    // Watchdog: end the run when no transfer happens on either side for too long.
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int         i;
        leg_t       leg;
        logic [3:0] c;

        drill[0]  = '{CMD_SUSPEND,     4'd0,  4'd0,  1'b1, INIT_INVALID};
        drill[1]  = '{CMD_RESUME,      4'd15, 4'd15, 1'b1, INIT_INVALID};
        drill[2]  = '{CMD_XRUN,        4'd8,  4'd8,  1'b1, INIT_INVALID};
        drill[3]  = '{CMD_UNKNOWN_TOP, 4'd0,  4'd0,  1'b1, INIT_INVALID};
        drill[4]  = '{CMD_START,       4'd0,  4'd0,  1'b1, INIT_INVALID};
        drill[5]  = '{CMD_RESET,       4'd0,  4'd0,  1'b1, READY_OK};
        drill[6]  = '{CMD_PREPARE,     4'd0,  4'd0,  1'b0, NO_RESULT};
        drill[7]  = '{CMD_PREPARE,     4'd3,  4'd0,  1'b0, NO_RESULT};
        drill[8]  = '{CMD_PRE_START,   4'd0,  4'd0,  1'b0, NO_RESULT};
        drill[9]  = '{CMD_START,       4'd0,  4'd15, 1'b0, NO_RESULT};
        drill[10] = '{CMD_STOP,        4'd15, 4'd0,  1'b0, NO_RESULT};
        drill[11] = '{CMD_PAUSE,       4'd0,  4'd1,  1'b0, NO_RESULT};
        drill[12] = '{CMD_PRE_START,   4'd0,  4'd0,  1'b0, NO_RESULT};
        drill[13] = '{CMD_RELEASE,     4'd0,  4'd0,  1'b0, NO_RESULT};
        drill[14] = '{CMD_STOP,        4'd0,  4'd9,  1'b0, NO_RESULT};
        drill[15] = '{CMD_PRE_RELEASE, 4'd0,  4'd0,  1'b0, NO_RESULT};
        drill[16] = '{CMD_START,       4'd0,  4'd0,  1'b0, NO_RESULT};
        drill[17] = '{CMD_START,       4'd1,  4'd1,  1'b0, NO_RESULT};
        drill[18] = '{CMD_RELEASE,     4'd0,  4'd0,  1'b0, NO_RESULT};
        drill[19] = '{CMD_PREPARE,     4'd0,  4'd0,  1'b0, NO_RESULT};
        drill[20] = '{CMD_PRE_START,   4'd0,  4'd0,  1'b0, NO_RESULT};
        drill[21] = '{CMD_PRE_RELEASE, 4'd0,  4'd0,  1'b0, NO_RESULT};
        drill[22] = '{CMD_PAUSE,       4'd0,  4'd2,  1'b0, NO_RESULT};
        drill[23] = '{CMD_PAUSE,       4'd1,  4'd0,  1'b0, NO_RESULT};
        drill[24] = '{CMD_STOP,        4'd0,  4'd0,  1'b0, NO_RESULT};
        drill[25] = '{CMD_RESET,       4'd0,  4'd0,  1'b1, READY_OK};

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DRILL_ROWS; i++)
            send_command(drill[i].cmd, drill[i].act, drill[i].pau, drill[i].typed,
                         drill[i].res);

        for (int l = 0; l < 4; l++)
        begin
            leg = leg_t'(l);
            case (leg)
                LEG_STEADY:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct <= 0;
                end
                LEG_SENDER_IDLE:
                begin
                    sender_idle_pct = 66;
                    receiver_stall_pct <= 0;
                end
                LEG_RECEIVER_STALL:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct <= 66;
                end
                default:
                begin
                    sender_idle_pct = 22;
                    receiver_stall_pct <= 22;
                end
            endcase
            // long receiver hold-off while the sender keeps offering, to back up the pipe
            if (leg == LEG_STEADY || leg == LEG_BOTH_IDLE)
                hold_req <= ~hold_req;
            for (i = 0; i < ITEMS_PER_LEG; i++)
            begin
                if ($urandom_range(99) < 70)
                    c = forward_cmd(tracked_state);
                else
                    c = 4'($urandom_range(15));
                send_command(c, neighbor_count(), neighbor_count(), 1'b0, NO_RESULT);
            end
        end

        s_axis_tvalid <= 1'b0;
        receiver_stall_pct <= 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### fork_trigger_state_machine.f
design/fts_pkg.sv
design/fork_trigger_state_machine.sv
dv/fork_trigger_state_machine_test.sv
